// ----- sv/cdwc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdwc_pkg
// Shared widths, constants and types of the causal depthwise convolution.
// ----------------------------------------------------------------------------
package cdwc_pkg;

   localparam int MAX_CHANNELS = 4096;
   localparam int TAPS         = 4;
   localparam int CH_W         = $clog2(MAX_CHANNELS);
   localparam int CNT_W        = 13;
   localparam int ROWS_W       = 2;
   localparam int SAMPLE_W     = 16;
   localparam int HIST_W       = SAMPLE_W * (TAPS - 1);
   localparam int PROD_W       = 2 * SAMPLE_W;
   localparam int ACC_W        = PROD_W + 2;
   localparam int FRAC_BITS    = 12;
   localparam int RND_W        = ACC_W - FRAC_BITS;

   // channel slot of one word: which history entry and how many rows are behind it
   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic [ROWS_W-1:0] rows;
   } slot_type;

endpackage

`default_nettype wire

// ----- sv/causal_depthwise_conv_k4.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// causal_depthwise_conv_k4
// Streaming 4-tap causal depthwise convolution over channel-interleaved rows.
// ----------------------------------------------------------------------------
// One word is taken per clock and one result word leaves per clock while the
// output is not stalled. A word's history is read into a register as the word
// is accepted; the multiply-accumulate enters the result register when stage 1
// moves on, which waits while rsp_stall holds the result register.
// The rate is set by the history memory, which does one read and one write
// per cycle; a word accepted at the edge that writes its channel's entry gets
// that new entry forwarded. The history memory needs no clearing after reset:
// taps from rows before the start of the tensor are masked to zero by the row
// counter. csr_channel_count must be written only while no word is in flight;
// the block does not enforce this. csr_ready is always high.
// ----------------------------------------------------------------------------
module causal_depthwise_conv_k4 (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_first_of_tensor,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] req_weight_tap0,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] req_weight_tap1,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] req_weight_tap2,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] req_weight_tap3,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      signed [cdwc_pkg::SAMPLE_W-1:0] rsp_result_sample,
   output logic                                      rsp_saturated,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic        [cdwc_pkg::CNT_W-1:0]    csr_channel_count
);

   localparam int SW = cdwc_pkg::SAMPLE_W;

   logic [cdwc_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       req_accept, rsp_free, s1_move;
   cdwc_pkg::slot_type         slot;

   // stage 1: accepted word plus its history read
   logic                          s1_valid_ff, s1_valid_in;
   cdwc_pkg::slot_type            s1_slot_ff;
   logic signed [SW-1:0]          s1_sample_ff, s1_w0_ff, s1_w1_ff, s1_w2_ff, s1_w3_ff;
   logic                          fwd_ff, fwd_in;
   logic [cdwc_pkg::HIST_W-1:0]   fwd_data_ff;
   logic [cdwc_pkg::HIST_W-1:0]   rd_data, hist, hist_new;
   logic signed [SW-1:0]          x1, x2, x3;
   logic signed [SW-1:0]          result_sample;
   logic                          saturated;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]          rsp_result_sample_ff;
   logic                          rsp_saturated_ff;

   assign csr_ready  = 1'b1;
   assign count_in   = (csr_valid && csr_ready) ? csr_channel_count : count_ff;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && rsp_free;
   assign req_stall  = s1_valid_ff && !rsp_free;
   assign req_accept = req_valid && !req_stall;

   cdwc_tracker u_tracker (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .first_of_tensor (req_first_of_tensor),
      .channel_count   (count_ff),
      .slot            (slot)
   );

   cdwc_history u_history (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (slot.channel),
      .rd_data (rd_data),
      .wr_en   (s1_move),
      .wr_addr (s1_slot_ff.channel),
      .wr_data (hist_new)
   );

   // history word: oldest tap in the top field
   always_comb begin
      hist     = fwd_ff ? fwd_data_ff : rd_data;
      hist_new = {hist[2*SW-1:0], s1_sample_ff};
      x1 = (s1_slot_ff.rows >= cdwc_pkg::ROWS_W'(1)) ? hist[SW-1:0]      : '0;
      x2 = (s1_slot_ff.rows >= cdwc_pkg::ROWS_W'(2)) ? hist[2*SW-1:SW]   : '0;
      x3 = (s1_slot_ff.rows >= cdwc_pkg::ROWS_W'(3)) ? hist[3*SW-1:2*SW] : '0;
      // same channel written this cycle: the read sees the old entry
      fwd_in = s1_move && (slot.channel == s1_slot_ff.channel);
   end

   cdwc_datapath u_datapath (
      .x0            (s1_sample_ff),
      .x1            (x1),
      .x2            (x2),
      .x3            (x3),
      .weight_tap0   (s1_w0_ff),
      .weight_tap1   (s1_w1_ff),
      .weight_tap2   (s1_w2_ff),
      .weight_tap3   (s1_w3_ff),
      .result_sample (result_sample),
      .saturated     (saturated)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= cdwc_pkg::CNT_W'(1);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_slot_ff   <= slot;
         s1_sample_ff <= req_sample;
         s1_w0_ff     <= req_weight_tap0;
         s1_w1_ff     <= req_weight_tap1;
         s1_w2_ff     <= req_weight_tap2;
         s1_w3_ff     <= req_weight_tap3;
         fwd_ff       <= fwd_in;
         fwd_data_ff  <= hist_new;
      end
      if (s1_move) begin
         rsp_result_sample_ff <= result_sample;
         rsp_saturated_ff     <= saturated;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_sample = rsp_result_sample_ff;
   assign rsp_saturated     = rsp_saturated_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   a_held_word_keeps_slot: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_free) |=> (s1_valid_ff && $stable(s1_slot_ff)))
      else $error("held word lost its slot");

   a_sat_is_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_saturated_ff) |->
         (rsp_result_sample_ff == SW'(16'sh7fff) || rsp_result_sample_ff == SW'(16'sh8000)))
      else $error("saturation flag without a clamped result");

endmodule

`default_nettype wire

// ----- sv/cdwc_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdwc_tracker
// Channel position and row counter; gives the slot of the word on offer.
// ----------------------------------------------------------------------------
module cdwc_tracker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic                       first_of_tensor,
   input  wire logic [cdwc_pkg::CNT_W-1:0] channel_count,
   output cdwc_pkg::slot_type              slot
);

   logic [cdwc_pkg::CH_W-1:0]   position_ff, position_in;
   logic [cdwc_pkg::ROWS_W-1:0] rows_ff, rows_in;
   logic [cdwc_pkg::CNT_W-1:0]  count_eff;
   logic [cdwc_pkg::CNT_W-1:0]  position_next;

   // out-of-range counts are clamped
   always_comb begin
      if (channel_count == '0) begin
         count_eff = cdwc_pkg::CNT_W'(1);
      end else if (channel_count > cdwc_pkg::CNT_W'(cdwc_pkg::MAX_CHANNELS)) begin
         count_eff = cdwc_pkg::CNT_W'(cdwc_pkg::MAX_CHANNELS);
      end else begin
         count_eff = channel_count;
      end
   end

   always_comb begin
      slot.channel  = first_of_tensor ? '0 : position_ff;
      slot.rows     = first_of_tensor ? '0 : rows_ff;
      position_next = cdwc_pkg::CNT_W'(slot.channel) + cdwc_pkg::CNT_W'(1);
      position_in   = position_ff;
      rows_in       = rows_ff;
      if (accept) begin
         // a position at or past the count closes the row too
         if (position_next >= count_eff) begin
            position_in = '0;
            rows_in     = (slot.rows == cdwc_pkg::ROWS_W'(cdwc_pkg::TAPS - 1))
                          ? slot.rows : slot.rows + cdwc_pkg::ROWS_W'(1);
         end else begin
            position_in = position_next[cdwc_pkg::CH_W-1:0];
            rows_in     = slot.rows;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         rows_ff     <= '0;
      end else begin
         position_ff <= position_in;
         rows_ff     <= rows_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/cdwc_history.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdwc_history
// Per-channel history memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cdwc_history (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [cdwc_pkg::CH_W-1:0]   rd_addr,
   output logic      [cdwc_pkg::HIST_W-1:0] rd_data,
   input  wire logic                        wr_en,
   input  wire logic [cdwc_pkg::CH_W-1:0]   wr_addr,
   input  wire logic [cdwc_pkg::HIST_W-1:0] wr_data
);

   logic [cdwc_pkg::HIST_W-1:0] mem [cdwc_pkg::MAX_CHANNELS];
   logic [cdwc_pkg::HIST_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/cdwc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdwc_datapath
// Four-tap multiply-accumulate with round-to-nearest and 16-bit saturation.
// ----------------------------------------------------------------------------
module cdwc_datapath (
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] x0,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] x1,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] x2,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] x3,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] weight_tap0,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] weight_tap1,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] weight_tap2,
   input  wire logic signed [cdwc_pkg::SAMPLE_W-1:0] weight_tap3,
   output logic      signed [cdwc_pkg::SAMPLE_W-1:0] result_sample,
   output logic                                      saturated
);

   localparam logic signed [cdwc_pkg::RND_W-1:0] SAT_HI =
      cdwc_pkg::RND_W'((1 << (cdwc_pkg::SAMPLE_W - 1)) - 1);
   localparam logic signed [cdwc_pkg::RND_W-1:0] SAT_LO =
      -cdwc_pkg::RND_W'(1 << (cdwc_pkg::SAMPLE_W - 1));
   localparam logic signed [cdwc_pkg::ACC_W-1:0] HALF_LSB =
      cdwc_pkg::ACC_W'(1 << (cdwc_pkg::FRAC_BITS - 1));

   logic signed [cdwc_pkg::PROD_W-1:0] p0, p1, p2, p3;
   logic signed [cdwc_pkg::ACC_W-1:0]  acc, acc_rnd;
   logic signed [cdwc_pkg::RND_W-1:0]  rounded;

   always_comb begin
      // x0 is the current word, x3 the one three rows back
      p3 = x0 * weight_tap3;
      p2 = x1 * weight_tap2;
      p1 = x2 * weight_tap1;
      p0 = x3 * weight_tap0;
      acc = cdwc_pkg::ACC_W'(p0) + cdwc_pkg::ACC_W'(p1)
          + cdwc_pkg::ACC_W'(p2) + cdwc_pkg::ACC_W'(p3);
      // ties round toward plus infinity
      acc_rnd = acc + HALF_LSB;
      rounded = acc_rnd[cdwc_pkg::ACC_W-1:cdwc_pkg::FRAC_BITS];
      if (rounded > SAT_HI) begin
         result_sample = SAT_HI[cdwc_pkg::SAMPLE_W-1:0];
         saturated     = 1'b1;
      end else if (rounded < SAT_LO) begin
         result_sample = SAT_LO[cdwc_pkg::SAMPLE_W-1:0];
         saturated     = 1'b1;
      end else begin
         result_sample = rounded[cdwc_pkg::SAMPLE_W-1:0];
         saturated     = 1'b0;
      end
   end

endmodule

`default_nettype wire
